[rtl/gc3_pkg.sv]
// shared constants for the 3x3 gaussian convolution unit
// no dependencies
`timescale 1ns / 1ps

package gc3_pkg;

    localparam int DEF_MAX_SIZE    = 2048;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int CFG_BITS      = 12;
    localparam int FILTERED_BITS = 20;
    localparam int INDEX_BITS    = 11;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam int MIN_SIZE      = 3;

    localparam logic REG_MATRIX_SIZE = 1'b0;

    localparam int OUT_PAYLOAD_BITS = FILTERED_BITS + 2 * INDEX_BITS;
    localparam int OUT_TDATA_BITS   = ((OUT_PAYLOAD_BITS + 7) / 8) * 8;

endpackage

[rtl/gc3_line_store.sv]
// one line store: single write port, single registered read port
// depends on nothing but its parameters
`timescale 1ns / 1ps

module gc3_line_store #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/gc3_cell.sv]
// window cell: holds one column (upper, middle, lower) and its vertical 1-2-1 sum
// passes the column on to the next cell on every shift
`timescale 1ns / 1ps

module gc3_cell #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_shift,
    input  logic [2:0][SAMPLE_BITS-1:0]         i_col,
    output logic [2:0][SAMPLE_BITS-1:0]         o_col,
    output logic signed [SAMPLE_BITS+1:0]       o_vsum
);

    logic [2:0][SAMPLE_BITS-1:0] r_col;
    logic signed [SAMPLE_BITS-1:0] w_top;
    logic signed [SAMPLE_BITS-1:0] w_mid;
    logic signed [SAMPLE_BITS-1:0] w_bot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign w_top = signed'(r_col[0]);
    assign w_mid = signed'(r_col[1]);
    assign w_bot = signed'(r_col[2]);

    assign o_col  = r_col;
    assign o_vsum = (SAMPLE_BITS+2)'(w_top) + ((SAMPLE_BITS+2)'(w_mid) <<< 1)
                  + (SAMPLE_BITS+2)'(w_bot);

endmodule

[rtl/gaussian_3x3_convolution_unit.sv]
// top level of the 3x3 gaussian convolution unit (kernel 1 2 1 / 2 4 2 / 1 2 1)
// uses gc3_pkg, gc3_line_store and gc3_cell
//
//   channel   dir  fields / width
//   s_axis    in   tdata: sample (SAMPLE_BITS, padded to bytes)
//   m_axis    out  tdata: filtered(20) out_row(11) out_col(11); tlast: last
//   apb       in   matrix_size at byte address 0 (12 bits)
//
// one beat per cycle sustained unless the output stalls; stage one registers the line
// store reads and bottom sample at acceptance; the window sum then goes to the output
// register. a beat is emitted only for interior positions. synchronous active-low reset:
// size returns to MAX_SIZE, counters and window to zero; line stores are not cleared.
// the output stalls the whole pipe only when the output register is full and not taken.
`timescale 1ns / 1ps

module gaussian_3x3_convolution_unit #(
    parameter int MAX_SIZE    = gc3_pkg::DEF_MAX_SIZE,
    parameter int SAMPLE_BITS = gc3_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // apb configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [gc3_pkg::APB_ADDR_BITS-1:0]      paddr,
    input  logic [gc3_pkg::APB_DATA_BITS-1:0]      pwdata,
    output logic [gc3_pkg::APB_DATA_BITS-1:0]      prdata,
    output logic                                   pready,
    // input stream
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       i_s_axis_tdata,  // sample
    // output stream
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    output logic [gc3_pkg::OUT_TDATA_BITS-1:0]     o_m_axis_tdata,  // filtered, out_row, out_col
    output logic                                   o_m_axis_tlast
);

    import gc3_pkg::*;

    localparam int ADDR_W = $clog2(MAX_SIZE);
    localparam int SZ_W   = (CFG_BITS > ADDR_W + 1) ? CFG_BITS : ADDR_W + 1;
    localparam int SUM_W  = SAMPLE_BITS + 4;

    // configuration
    logic [CFG_BITS-1:0] r_size;
    logic [ADDR_W-1:0]   r_last_idx;
    logic [SZ_W-1:0]     w_size_in;
    logic [SZ_W-1:0]     w_size_eff;
    logic                w_cfg_wr;

    // position counters
    logic [ADDR_W-1:0] r_row;
    logic [ADDR_W-1:0] r_col;
    logic [ADDR_W-1:0] n_row;
    logic [ADDR_W-1:0] n_col;

    // stage one
    logic                   r_s1_valid;
    logic [SAMPLE_BITS-1:0] r_s1_bot;
    logic [ADDR_W-1:0]      r_s1_col;
    logic [INDEX_BITS-1:0]  r_s1_orow;
    logic [INDEX_BITS-1:0]  r_s1_ocol;
    logic                   r_s1_prod;
    logic                   r_s1_last;
    logic [SAMPLE_BITS-1:0] w_top;
    logic [SAMPLE_BITS-1:0] w_mid;

    // output register
    logic                     r_out_valid;
    logic [FILTERED_BITS-1:0] r_out_filt;
    logic [INDEX_BITS-1:0]    r_out_row;
    logic [INDEX_BITS-1:0]    r_out_col;
    logic                     r_out_last;

    logic w_in_fire;
    logic w_s1_adv;
    logic w_out_free;

    // window
    logic [2:0][SAMPLE_BITS-1:0]  w_col0;
    logic [2:0][SAMPLE_BITS-1:0]  w_col1;
    logic [2:0][SAMPLE_BITS-1:0]  w_col2;
    logic signed [SAMPLE_BITS+1:0] w_v0;
    logic signed [SAMPLE_BITS+1:0] w_v1;
    logic signed [SAMPLE_BITS+1:0] w_v2;
    logic signed [SUM_W-1:0]       w_sum;

    // apb
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MATRIX_SIZE);
    assign prdata   = (paddr[2] == REG_MATRIX_SIZE) ? APB_DATA_BITS'(r_size) : '0;

    assign w_size_in  = SZ_W'(pwdata[CFG_BITS-1:0]);
    assign w_size_eff = (w_size_in < SZ_W'(MIN_SIZE)) ? SZ_W'(MIN_SIZE) :
                        (w_size_in > SZ_W'(MAX_SIZE)) ? SZ_W'(MAX_SIZE) : w_size_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size     <= CFG_BITS'(MAX_SIZE);
            r_last_idx <= ADDR_W'(MAX_SIZE - 1);
        end else if (w_cfg_wr) begin
            r_size     <= pwdata[CFG_BITS-1:0];
            r_last_idx <= ADDR_W'(w_size_eff - SZ_W'(1));
        end
    end

    // handshakes
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_s1_adv        = r_s1_valid && w_out_free;
    assign o_s_axis_tready = !r_s1_valid || w_s1_adv;
    assign w_in_fire       = i_s_axis_tvalid && o_s_axis_tready;

    // counters
    always_comb begin
        n_row = r_row;
        n_col = r_col + ADDR_W'(1);
        if (r_col == r_last_idx) begin
            n_col = '0;
            n_row = (r_row == r_last_idx) ? '0 : r_row + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (w_cfg_wr) begin
            r_row <= '0;
            r_col <= '0;
        end else if (w_in_fire) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // line stores
    gc3_line_store #(
        .DEPTH (MAX_SIZE),
        .WIDTH (SAMPLE_BITS)
    ) u_store_upper (
        .i_clk   (i_clk),
        .i_we    (w_s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (w_mid),
        .i_re    (w_in_fire),
        .i_raddr (r_col),
        .o_rdata (w_top)
    );

    gc3_line_store #(
        .DEPTH (MAX_SIZE),
        .WIDTH (SAMPLE_BITS)
    ) u_store_middle (
        .i_clk   (i_clk),
        .i_we    (w_s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_bot),
        .i_re    (w_in_fire),
        .i_raddr (r_col),
        .o_rdata (w_mid)
    );

    // stage one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_bot  <= i_s_axis_tdata[SAMPLE_BITS-1:0];
            r_s1_col  <= r_col;
            r_s1_orow <= INDEX_BITS'(r_row - ADDR_W'(1));
            r_s1_ocol <= INDEX_BITS'(r_col - ADDR_W'(1));
            r_s1_prod <= (r_row >= ADDR_W'(2)) && (r_col >= ADDR_W'(2));
            r_s1_last <= (r_row == r_last_idx) && (r_col == r_last_idx);
        end
    end

    // window chain
    assign w_col0[0] = w_top;
    assign w_col0[1] = w_mid;
    assign w_col0[2] = r_s1_bot;

    assign w_v0 = (SAMPLE_BITS+2)'(signed'(w_top)) + ((SAMPLE_BITS+2)'(signed'(w_mid)) <<< 1)
                + (SAMPLE_BITS+2)'(signed'(r_s1_bot));

    gc3_cell #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (w_s1_adv),
        .i_col   (w_col0),
        .o_col   (w_col1),
        .o_vsum  (w_v1)
    );

    gc3_cell #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (w_s1_adv),
        .i_col   (w_col1),
        .o_col   (w_col2),
        .o_vsum  (w_v2)
    );

    assign w_sum = SUM_W'(w_v0) + (SUM_W'(w_v1) <<< 1) + SUM_W'(w_v2);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_s1_adv && r_s1_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && r_s1_prod) begin
            r_out_filt <= FILTERED_BITS'(w_sum);
            r_out_row  <= r_s1_orow;
            r_out_col  <= r_s1_ocol;
            r_out_last <= r_s1_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_BITS'({r_out_col, r_out_row, r_out_filt});
    assign o_m_axis_tlast  = r_out_last;

endmodule
